// ===== src/hvd_pkg.sv =====
package hvd_pkg;

  // Default fixed-point settings.
  localparam int ANGLE_FRAC_BITS_DEF = 16;
  localparam int DIST_FRAC_BITS_DEF  = 8;

  // Width of angle magnitudes in degrees. It covers 180 degrees with up to
  // 25 fraction bits.
  localparam int ANG_W = 34;

  // Q30 constants, the distance ceiling and the reset radius in km.
  localparam logic [24:0] DEG_TO_RAD_Q30 = 25'd18740330;
  localparam logic [30:0] HALF_PI_Q30    = 31'd1686629713;
  localparam logic [30:0] ONE_Q30        = 31'd1073741824;
  localparam logic [30:0] HALF_Q30       = 31'd536870912;
  localparam logic [25:0] DIST_MAX       = 26'd67108863;
  localparam logic [15:0] RADIUS_RESET   = 16'd6371;

  // Status codes.
  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_ORIG_BAD  = 2'd1;
  localparam logic [1:0] STAT_DEST_BAD  = 2'd2;

  // Taylor series of the sine: term k is divided by (2k)(2k+1).
  localparam int TAYLOR_TERMS = 8;
  localparam logic [8:0] TERM_DIV [1:8] = '{
    9'd6, 9'd20, 9'd42, 9'd72, 9'd110, 9'd156, 9'd210, 9'd272
  };
  // floor(2^32 / TERM_DIV[k]).
  localparam logic [29:0] TERM_RECIP [1:8] = '{
    30'd715827882, 30'd214748364, 30'd102261126, 30'd59652323,
    30'd39045157, 30'd27531841, 30'd20452225, 30'd15790320
  };

  // Pipeline depths.
  localparam int SIN_LAT     = 2 + 3 * TAYLOR_TERMS;
  localparam int SQRT_STEPS  = 31;
  localparam int ASIN_STEPS  = 30;
  localparam int BACK_STAGES = 1 + SIN_LAT + 2 + SQRT_STEPS
                             + ASIN_STEPS * (SIN_LAT + 1) + 3;

  // One classified item between the front and the back.
  typedef struct packed {
    logic [1:0]       status;
    logic [ANG_W-1:0] hdlat;   // |lat1 - lat2|, one extra fraction bit
    logic [ANG_W-1:0] hdlon;   // folded |lon1 - lon2|, one extra fraction bit
    logic [ANG_W-1:0] colat1;  // 90 - |lat1|
    logic [ANG_W-1:0] colat2;  // 90 - |lat2|
  } hvd_item_t;

  localparam int ITEM_W = $bits(hvd_item_t);

endpackage

// ===== src/haversine_distance.sv =====
// Great-circle distance between two points by the haversine formula.
// Input stream: s_axis carries one pair of points per transaction, each
// coordinate in signed degrees scaled by 2^ANGLE_FRAC_BITS. Output stream:
// m_axis carries the distance in 1/2^DIST_FRAC_BITS km on tdata and the
// status on tuser (0 ok, 1 origin invalid, 2 destination invalid; distance
// is zero on error).
// Configuration: a write on cfg_valid/cfg_data sets the sphere radius in
// km; cfg_ready is always high. Write it only while no item is in flight.
// Throughput: one transaction per cycle in both directions while the
// receiver keeps m_axis_tready high. From input to output an item
// passes one front register, one queue slot, and an 873-stage
// arithmetic pipeline dominated by the thirty bisection steps of the
// arcsine, each of which runs a full pipelined sine.
// Reset clears all valid bits, empties the queue and sets the radius to
// 6371 km. When a result waits and m_axis_tready is low the whole pipeline
// freezes, the two-entry queue fills, and then s_axis_tready drops.
module haversine_distance #(
  parameter int ANGLE_FRAC_BITS = hvd_pkg::ANGLE_FRAC_BITS_DEF,
  parameter int DIST_FRAC_BITS  = hvd_pkg::DIST_FRAC_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  // origin_lat[23:0], origin_lon[48:24], dest_lat[72:49], dest_lon[97:73]
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [103:0] s_axis_tdata,
  // distance[25:0]
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [31:0]  m_axis_tdata,
  // status[1:0]
  output logic [1:0]   m_axis_tuser,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [15:0]  cfg_data
);
  import hvd_pkg::*;

  logic        front_valid, front_taken, q_full, q_valid, q_pop;
  hvd_item_t   front_item, q_item;
  logic [15:0] radius;
  logic [25:0] distance;

  // Radius register.
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      radius <= RADIUS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      radius <= cfg_data;
    end
  end

  hvd_front #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_front (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .item_valid(front_valid), .item_taken(front_taken), .item(front_item)
  );

  assign front_taken = front_valid && !q_full;

  hvd_fifo #(.WIDTH(ITEM_W), .DEPTH(2)) u_queue (
    .clk(clk), .rst(rst),
    .wr_en(front_taken), .wr_data(front_item), .full(q_full),
    .rd_en(q_pop), .rd_data(q_item), .not_empty(q_valid)
  );

  logic back_ready;
  assign q_pop = q_valid && back_ready;

  hvd_back #(
    .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS),
    .DIST_FRAC_BITS(DIST_FRAC_BITS)
  ) u_back (
    .clk(clk), .rst(rst),
    .item_valid(q_valid), .item_ready(back_ready), .item(q_item),
    .radius(radius),
    .res_valid(m_axis_tvalid), .res_ready(m_axis_tready),
    .res_distance(distance), .res_status(m_axis_tuser)
  );

  assign m_axis_tdata = {6'b0, distance};
endmodule

// ===== src/hvd_fifo.sv =====
module hvd_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             not_empty
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0]     mem [DEPTH];
  logic [AW-1:0]        wr_ptr;
  logic [AW-1:0]        rd_ptr;
  logic [$clog2(DEPTH+1)-1:0] count;

  assign full      = (count == ($clog2(DEPTH+1))'(DEPTH));
  assign not_empty = (count != '0);
  assign rd_data   = mem[rd_ptr];

  // Storage write.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (wr_en && !rd_en) begin
        count <= count + 1'b1;
      end else if (!wr_en && rd_en) begin
        count <= count - 1'b1;
      end
    end
  end
endmodule

// ===== src/hvd_front.sv =====
module hvd_front #(
  parameter int ANGLE_FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [103:0]       s_axis_tdata,
  output logic               item_valid,
  input  logic               item_taken,
  output hvd_pkg::hvd_item_t item
);
  import hvd_pkg::*;

  localparam logic [ANG_W-1:0] LAT_MAX  = ANG_W'(90) << ANGLE_FRAC_BITS;
  localparam logic [ANG_W-1:0] LON_MAX  = ANG_W'(180) << ANGLE_FRAC_BITS;
  localparam logic [ANG_W-1:0] HALF_MAX = ANG_W'(90) << (ANGLE_FRAC_BITS + 1);
  localparam logic [ANG_W-1:0] FULL_MAX = ANG_W'(180) << (ANGLE_FRAC_BITS + 1);

  logic signed [ANG_W-1:0] olat, olon, dlat, dlon, dif_lat, dif_lon;
  logic [ANG_W-1:0] olat_m, olon_m, dlat_m, dlon_m, hdlat, hdlon_raw;
  logic             orig_ok, dest_ok;
  hvd_item_t        item_next;

  function automatic logic [ANG_W-1:0] mag(input logic signed [ANG_W-1:0] v);
    mag = v[ANG_W-1] ? ANG_W'(-v) : ANG_W'(v);
  endfunction

  // Unpack and sign-extend the four coordinates.
  assign olat = ANG_W'($signed(s_axis_tdata[23:0]));
  assign olon = ANG_W'($signed(s_axis_tdata[48:24]));
  assign dlat = ANG_W'($signed(s_axis_tdata[72:49]));
  assign dlon = ANG_W'($signed(s_axis_tdata[97:73]));

  // Range check and half-angle differences.
  always_comb begin
    olat_m    = mag(olat);
    olon_m    = mag(olon);
    dlat_m    = mag(dlat);
    dlon_m    = mag(dlon);
    orig_ok   = (olat_m <= LAT_MAX) && (olon_m <= LON_MAX);
    dest_ok   = (dlat_m <= LAT_MAX) && (dlon_m <= LON_MAX);
    dif_lat   = olat - dlat;
    dif_lon   = olon - dlon;
    hdlat     = mag(dif_lat);
    hdlon_raw = mag(dif_lon);
    item_next.hdlat  = hdlat;
    item_next.hdlon  = (hdlon_raw > HALF_MAX) ? FULL_MAX - hdlon_raw : hdlon_raw;
    item_next.colat1 = LAT_MAX - olat_m;
    item_next.colat2 = LAT_MAX - dlat_m;
    priority if (!orig_ok) begin
      item_next.status = STAT_ORIG_BAD;
    end else if (!dest_ok) begin
      item_next.status = STAT_DEST_BAD;
    end else begin
      item_next.status = STAT_OK;
    end
  end

  assign s_axis_tready = !item_valid || item_taken;

  // Front register.
  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      item <= item_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      item_valid <= 1'b1;
    end else if (item_taken) begin
      item_valid <= 1'b0;
    end
  end
endmodule

// ===== src/hvd_sin.sv =====
module hvd_sin #(
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          en,
  input  logic [31:0]   x,
  input  logic [SW-1:0] side_in,
  output logic [30:0]   y,
  output logic [SW-1:0] side_out
);
  import hvd_pkg::*;

  logic [31:0]        x2_s   [0:TAYLOR_TERMS];
  logic [30:0]        term_s [0:TAYLOR_TERMS];
  logic signed [33:0] sum_s  [0:TAYLOR_TERMS];
  logic [SW-1:0]      side_s [0:TAYLOR_TERMS];
  logic [30:0]        xc;
  logic [61:0]        xsq;

  // Clamp to pi/2 and square.
  assign xc  = (x > 32'(HALF_PI_Q30)) ? HALF_PI_Q30 : x[30:0];
  assign xsq = 62'(xc) * 62'(xc);

  always_ff @(posedge clk) begin
    if (en) begin
      x2_s[0]   <= xsq[61:30];
      term_s[0] <= xc;
      sum_s[0]  <= 34'(xc);
      side_s[0] <= side_in;
    end
  end

  // One series term per three stages: product, reciprocal, correction.
  for (genvar k = 1; k <= TAYLOR_TERMS; k++) begin : g_term
    logic [31:0]        pa, pb, x2a, x2b, r;
    logic signed [33:0] suma, sumb;
    logic [SW-1:0]      sidea, sideb;
    logic [29:0]        qe;
    logic [62:0]        prod_a;
    logic [61:0]        prod_b;
    logic [38:0]        qd;
    logic [30:0]        q;

    assign prod_a = 63'(term_s[k-1]) * 63'(x2_s[k-1]);
    assign prod_b = 62'(pa) * 62'(TERM_RECIP[k]);
    assign qd     = 39'(qe) * 39'(TERM_DIV[k]);
    assign r      = pb - qd[31:0];
    assign q      = 31'(qe) + ((r >= 32'(TERM_DIV[k])) ? 31'd1 : 31'd0);

    always_ff @(posedge clk) begin
      if (en) begin
        pa        <= prod_a[61:30];
        x2a       <= x2_s[k-1];
        suma      <= sum_s[k-1];
        sidea     <= side_s[k-1];
        qe        <= prod_b[61:32];
        pb        <= pa;
        x2b       <= x2a;
        sumb      <= suma;
        sideb     <= sidea;
        term_s[k] <= q;
        x2_s[k]   <= x2b;
        sum_s[k]  <= (k % 2 == 1) ? sumb - 34'(q) : sumb + 34'(q);
        side_s[k] <= sideb;
      end
    end
  end

  // Clamp the sum to [0, 1].
  always_ff @(posedge clk) begin
    if (en) begin
      if (sum_s[TAYLOR_TERMS] < 0) begin
        y <= '0;
      end else if (sum_s[TAYLOR_TERMS] > 34'(ONE_Q30)) begin
        y <= ONE_Q30;
      end else begin
        y <= sum_s[TAYLOR_TERMS][30:0];
      end
      side_out <= side_s[TAYLOR_TERMS];
    end
  end
endmodule

// ===== src/hvd_back.sv =====
module hvd_back #(
  parameter int ANGLE_FRAC_BITS = 16,
  parameter int DIST_FRAC_BITS  = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_ready,
  input  hvd_pkg::hvd_item_t item,
  input  logic [15:0]        radius,
  output logic               res_valid,
  input  logic               res_ready,
  output logic [25:0]        res_distance,
  output logic [1:0]         res_status
);
  import hvd_pkg::*;

  localparam int PW = ANG_W + 25;
  localparam int SIDE_W = 30 + 31 + 1 + 2;
  localparam logic [48:0] ROUND_ADD = 49'(1) << (29 - DIST_FRAC_BITS);

  logic                   en;
  logic [BACK_STAGES-1:0] vld;

  assign en         = !vld[BACK_STAGES-1] || res_ready;
  assign item_ready = en;
  assign res_valid  = vld[BACK_STAGES-1];

  // Valid bits follow the data through every stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[BACK_STAGES-2:0], item_valid};
    end
  end

  // Degrees to radians.
  logic [PW-1:0] p_s1, p_s2, p_c1, p_c2;
  logic [31:0]   x_s1, x_s2, x_c1, x_c2;
  logic [1:0]    stat_r1;

  assign p_s1 = (PW'(item.hdlat)  * PW'(DEG_TO_RAD_Q30)) >> (ANGLE_FRAC_BITS + 1);
  assign p_s2 = (PW'(item.hdlon)  * PW'(DEG_TO_RAD_Q30)) >> (ANGLE_FRAC_BITS + 1);
  assign p_c1 = (PW'(item.colat1) * PW'(DEG_TO_RAD_Q30)) >> ANGLE_FRAC_BITS;
  assign p_c2 = (PW'(item.colat2) * PW'(DEG_TO_RAD_Q30)) >> ANGLE_FRAC_BITS;

  always_ff @(posedge clk) begin
    if (en) begin
      x_s1    <= p_s1[31:0];
      x_s2    <= p_s2[31:0];
      x_c1    <= p_c1[31:0];
      x_c2    <= p_c2[31:0];
      stat_r1 <= item.status;
    end
  end

  // Four sines in parallel; the status rides along with the first.
  logic [30:0] s1, s2, c1, c2;
  logic [1:0]  stat_r2;

  hvd_sin #(.SW(2)) u_sin_s1 (
    .clk(clk), .en(en), .x(x_s1), .side_in(stat_r1), .y(s1), .side_out(stat_r2)
  );
  hvd_sin #(.SW(1)) u_sin_s2 (
    .clk(clk), .en(en), .x(x_s2), .side_in(1'b0), .y(s2), .side_out()
  );
  hvd_sin #(.SW(1)) u_sin_c1 (
    .clk(clk), .en(en), .x(x_c1), .side_in(1'b0), .y(c1), .side_out()
  );
  hvd_sin #(.SW(1)) u_sin_c2 (
    .clk(clk), .en(en), .x(x_c2), .side_in(1'b0), .y(c2), .side_out()
  );

  // Squares and cosine product.
  logic [61:0] m_s1, m_s2, m_cc;
  logic [30:0] sq1, sq2, cc;
  logic [1:0]  stat_r3;

  assign m_s1 = 62'(s1) * 62'(s1);
  assign m_s2 = 62'(s2) * 62'(s2);
  assign m_cc = 62'(c1) * 62'(c2);

  always_ff @(posedge clk) begin
    if (en) begin
      sq1     <= m_s1[60:30];
      sq2     <= m_s2[60:30];
      cc      <= m_cc[60:30];
      stat_r3 <= stat_r2;
    end
  end

  // The haversine sum a, and the choice of complement for large a.
  logic [61:0] m_a;
  logic [31:0] a_sum;
  logic [30:0] a_c;
  logic        large_c;
  logic [30:0] v_r;
  logic        large_r;
  logic [1:0]  stat_r4;

  assign m_a     = 62'(cc) * 62'(sq2);
  assign a_sum   = 32'(sq1) + 32'(m_a[60:30]);
  assign a_c     = (a_sum > 32'(ONE_Q30)) ? ONE_Q30 : a_sum[30:0];
  assign large_c = (a_c > HALF_Q30);

  always_ff @(posedge clk) begin
    if (en) begin
      v_r     <= large_c ? ONE_Q30 - a_c : a_c;
      large_r <= large_c;
      stat_r4 <= stat_r3;
    end
  end

  // Square root, one result bit per stage.
  logic [60:0] rem_s   [0:SQRT_STEPS];
  logic [61:0] root_s  [0:SQRT_STEPS];
  logic        large_q [0:SQRT_STEPS];
  logic [1:0]  stat_q  [0:SQRT_STEPS];

  assign rem_s[0]   = {v_r, 30'b0};
  assign root_s[0]  = '0;
  assign large_q[0] = large_r;
  assign stat_q[0]  = stat_r4;

  for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_sqrt
    localparam logic [61:0] BIT = 62'(1) << (60 - 2 * i);
    logic [61:0] trial;
    assign trial = root_s[i] + BIT;

    always_ff @(posedge clk) begin
      if (en) begin
        if ({1'b0, rem_s[i]} >= trial) begin
          rem_s[i+1]  <= rem_s[i] - trial[60:0];
          root_s[i+1] <= (root_s[i] >> 1) + BIT;
        end else begin
          rem_s[i+1]  <= rem_s[i];
          root_s[i+1] <= root_s[i] >> 1;
        end
        large_q[i+1] <= large_q[i];
        stat_q[i+1]  <= stat_q[i];
      end
    end
  end

  // Arcsine by bisection on the sine, one angle bit per iteration.
  logic [29:0] th_s   [0:ASIN_STEPS];
  logic [30:0] v_s    [0:ASIN_STEPS];
  logic        lg_s   [0:ASIN_STEPS];
  logic [1:0]  st_s   [0:ASIN_STEPS];

  assign th_s[0] = '0;
  assign v_s[0]  = root_s[SQRT_STEPS][30:0];
  assign lg_s[0] = large_q[SQRT_STEPS];
  assign st_s[0] = stat_q[SQRT_STEPS];

  for (genvar j = 0; j < ASIN_STEPS; j++) begin : g_asin
    localparam logic [29:0] BIT = 30'(1) << (29 - j);
    logic [30:0]       y;
    logic [SIDE_W-1:0] side_o;
    logic [29:0]       th_o;
    logic [30:0]       v_o;

    hvd_sin #(.SW(SIDE_W)) u_sin (
      .clk(clk), .en(en), .x(32'(th_s[j] | BIT)),
      .side_in({th_s[j], v_s[j], lg_s[j], st_s[j]}),
      .y(y), .side_out(side_o)
    );

    assign th_o = side_o[SIDE_W-1 -: 30];
    assign v_o  = side_o[33:3];

    always_ff @(posedge clk) begin
      if (en) begin
        th_s[j+1] <= (y <= v_o) ? (th_o | BIT) : th_o;
        v_s[j+1]  <= v_o;
        lg_s[j+1] <= side_o[2];
        st_s[j+1] <= side_o[1:0];
      end
    end
  end

  // Central angle, then scale by the radius, then round and saturate.
  logic [31:0] theta;
  logic [1:0]  stat_r5, stat_r6;
  logic [47:0] prod;
  logic [48:0] rounded;
  logic [30:0] asn;

  assign asn = lg_s[ASIN_STEPS] ? HALF_PI_Q30 - 31'(th_s[ASIN_STEPS])
                                : 31'(th_s[ASIN_STEPS]);

  always_ff @(posedge clk) begin
    if (en) begin
      theta   <= {asn, 1'b0};
      stat_r5 <= st_s[ASIN_STEPS];
      prod    <= 48'(radius) * 48'(theta);
      stat_r6 <= stat_r5;
    end
  end

  assign rounded = (49'(prod) + ROUND_ADD) >> (30 - DIST_FRAC_BITS);

  // Output register.
  always_ff @(posedge clk) begin
    if (en) begin
      res_status <= stat_r6;
      if (stat_r6 != STAT_OK) begin
        res_distance <= '0;
      end else if (rounded > 49'(DIST_MAX)) begin
        res_distance <= DIST_MAX;
      end else begin
        res_distance <= rounded[25:0];
      end
    end
  end
endmodule

// ===== test/haversine_distance_test.sv =====
`default_nettype none

module haversine_distance_test;
  timeunit 1ns;
  timeprecision 1ps;

  import hvd_pkg::*;

  localparam longint unsigned DEG = 64'd65536;
  localparam longint unsigned RAD_PER_DEG = 64'd18740330;
  localparam longint unsigned HALF_PI = 64'd1686629713;
  localparam longint unsigned UNIT = 64'd1 << 30;
  localparam longint unsigned SAT_DIST = 64'd67108863;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct {
    logic [25:0] distance;
    logic [1:0]  status;
  } hav_result_t;

  typedef struct {
    logic signed [23:0] olat;
    logic signed [24:0] olon;
    logic signed [23:0] dlat;
    logic signed [24:0] dlon;
    bit                 typed;
    logic [1:0]         status;
  } pair_row_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [103:0] s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [31:0]  m_axis_tdata;
  logic [1:0]   m_axis_tuser;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [15:0]  cfg_data = '0;

  hav_result_t  pending_dist[$];
  longint unsigned radius_km = RADIUS_RESET;
  int           error_count = 0;
  int           send_idle_pct = 0;
  int           recv_idle_pct = 0;
  bit           recv_hold = 1'b0;
  int           cycle_count = 0;

  haversine_distance u_dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  // Clock with a 4 ns period.
  always #2 clk = ~clk;

  // Sine of a Q30 angle in [0, pi/2] by a truncated Taylor series.
  function automatic longint unsigned sine_q30(longint unsigned x);
    longint unsigned x2, term;
    longint sum;
    if (x > HALF_PI) begin
      x = HALF_PI;
    end
    x2 = (x * x) >> 30;
    term = x;
    sum = longint'(x);
    for (int k = 1; k <= 8; k++) begin
      term = ((term * x2) >> 30) / longint'((2 * k) * (2 * k + 1));
      if (k % 2 == 1) begin
        sum -= longint'(term);
      end else begin
        sum += longint'(term);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    if (sum > longint'(UNIT)) begin
      sum = longint'(UNIT);
    end
    return longint'(sum);
  endfunction

  function automatic longint unsigned sine_of_deg(longint unsigned mag, int frac);
    return sine_q30((mag * RAD_PER_DEG) >> frac);
  endfunction

  // Bitwise integer square root.
  function automatic longint unsigned int_root(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) begin
      b >>= 2;
    end
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // Arcsine by bisection over the same sine.
  function automatic longint unsigned arcsine_q30(longint unsigned v);
    longint unsigned th;
    th = 0;
    for (int i = 29; i >= 0; i--) begin
      if (sine_q30(th | (64'd1 << i)) <= v) begin
        th |= 64'd1 << i;
      end
    end
    return th;
  endfunction

  function automatic longint unsigned magnitude(longint v);
    return (v < 0) ? longint'(-v) : longint'(v);
  endfunction

  function automatic bit point_valid(longint lat, longint lon);
    return magnitude(lat) <= 90 * DEG && magnitude(lon) <= 180 * DEG;
  endfunction

  // Great-circle distance of one pair of points at the current radius.
  function automatic hav_result_t predict_distance(pair_row_t p);
    hav_result_t res;
    longint lat1, lon1, lat2, lon2;
    longint unsigned hdlat, hdlon, s1, s2, c1, c2, a, asn, dist_fx;
    lat1 = p.olat;
    lon1 = p.olon;
    lat2 = p.dlat;
    lon2 = p.dlon;
    res.distance = '0;
    if (!point_valid(lat1, lon1)) begin
      res.status = STAT_ORIG_BAD;
      return res;
    end
    if (!point_valid(lat2, lon2)) begin
      res.status = STAT_DEST_BAD;
      return res;
    end
    hdlat = magnitude(lat1 - lat2);
    hdlon = magnitude(lon1 - lon2);
    if (hdlon > (90 * DEG) << 1) begin
      hdlon = ((180 * DEG) << 1) - hdlon;
    end
    s1 = sine_of_deg(hdlat, 17);
    s2 = sine_of_deg(hdlon, 17);
    c1 = sine_of_deg(90 * DEG - magnitude(lat1), 16);
    c2 = sine_of_deg(90 * DEG - magnitude(lat2), 16);
    a = ((s1 * s1) >> 30) + ((((c1 * c2) >> 30) * ((s2 * s2) >> 30)) >> 30);
    if (a > UNIT) begin
      a = UNIT;
    end
    // Beyond one half the complement keeps the bisection well conditioned.
    if (2 * a > UNIT) begin
      asn = HALF_PI - arcsine_q30(int_root((UNIT - a) << 30));
    end else begin
      asn = arcsine_q30(int_root(a << 30));
    end
    dist_fx = (radius_km * (2 * asn) + (64'd1 << 21)) >> 22;
    if (dist_fx > SAT_DIST) begin
      dist_fx = SAT_DIST;
    end
    res.distance = dist_fx[25:0];
    res.status = STAT_OK;
    return res;
  endfunction

  // Offer one pair and record its expected result once the transaction is taken.
  task automatic send_pair(pair_row_t p);
    hav_result_t res;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      @(negedge clk);
      s_axis_tvalid <= 1'b0;
    end
    @(negedge clk);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {6'b0, p.dlon, p.dlat, p.olon, p.olat};
    do @(posedge clk); while (!s_axis_tready);
    if (p.typed) begin
      res.distance = '0;
      res.status = p.status;
    end else begin
      res = predict_distance(p);
    end
    pending_dist.push_back(res);
  endtask

  task automatic write_radius(logic [15:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    radius_km = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain_results();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (pending_dist.size() != 0) begin
      @(posedge clk);
    end
    repeat (20) @(posedge clk);
  endtask

  function automatic logic signed [23:0] rand_lat();
    return 24'(int'($urandom_range(0, 180 * 65536)) - 90 * 65536);
  endfunction

  function automatic logic signed [24:0] rand_lon();
    return 25'(int'($urandom_range(0, 360 * 65536)) - 180 * 65536);
  endfunction

  // Random pair: mostly valid points, with edges, close pairs and raw noise.
  function automatic pair_row_t random_pair();
    pair_row_t p;
    int kind;
    kind = $urandom_range(0, 99);
    p.typed = 1'b0;
    p.status = STAT_OK;
    p.olat = rand_lat();
    p.olon = rand_lon();
    p.dlat = rand_lat();
    p.dlon = rand_lon();
    if (kind < 12) begin
      p.olat = 24'($urandom());
      p.olon = 25'($urandom());
      p.dlat = 24'($urandom());
      p.dlon = 25'($urandom());
    end else if (kind < 22) begin
      p.olat = 24'(($urandom_range(0, 1) ? 1 : -1)
                   * (90 * 65536 + int'($urandom_range(0, 2)) - 1));
      p.dlon = 25'(($urandom_range(0, 1) ? 1 : -1)
                   * (180 * 65536 + int'($urandom_range(0, 2)) - 1));
    end else if (kind < 35) begin
      p.dlat = p.olat + 24'(int'($urandom_range(0, 512)) - 256);
      p.dlon = p.olon + 25'(int'($urandom_range(0, 512)) - 256);
    end
    return p;
  endfunction

  localparam int N_ROWS = 16;
  localparam int D90 = 90 * 65536;
  localparam int D180 = 180 * 65536;
  pair_row_t directed_rows[N_ROWS] = '{
    // Same point twice.
    '{24'sd0, 25'sd0, 24'sd0, 25'sd0, 1'b0, STAT_OK},
    // Pole to pole.
    '{24'(D90), 25'sd0, 24'(-D90), 25'sd0, 1'b0, STAT_OK},
    // Antipodes on the equator, large a.
    '{24'sd0, 25'sd0, 24'sd0, 25'(D180), 1'b0, STAT_OK},
    // Both sides of the date line: longitude difference folds to zero.
    '{24'sd0, 25'(-D180), 24'sd0, 25'(D180), 1'b0, STAT_OK},
    '{24'sd0, 25'sd0, 24'sd0, 25'(90 * 65536), 1'b0, STAT_OK},
    '{24'sd0, 25'sd0, 24'sd0, 25'(120 * 65536), 1'b0, STAT_OK},
    '{24'sd1, 25'sd0, 24'sd0, 25'sd1, 1'b0, STAT_OK},
    '{24'(-D90), 25'(-D180), 24'(D90), 25'(D180), 1'b0, STAT_OK},
    // Origin just out of range.
    '{24'(D90 + 1), 25'sd0, 24'sd0, 25'sd0, 1'b1, STAT_ORIG_BAD},
    '{24'sd0, 25'(-D180 - 1), 24'sd0, 25'sd0, 1'b1, STAT_ORIG_BAD},
    // Destination just out of range.
    '{24'sd0, 25'sd0, 24'(-D90 - 1), 25'sd0, 1'b1, STAT_DEST_BAD},
    '{24'sd0, 25'sd0, 24'sd0, 25'(D180 + 1), 1'b1, STAT_DEST_BAD},
    // Both invalid: the origin wins.
    '{24'(D90 + 1), 25'sd0, 24'(D90 + 1), 25'sd0, 1'b1, STAT_ORIG_BAD},
    // Field extremes.
    '{24'h800000, 25'h1000000, 24'h800000, 25'h1000000, 1'b1, STAT_ORIG_BAD},
    '{24'h7fffff, 25'h0ffffff, 24'h7fffff, 25'h0ffffff, 1'b1, STAT_ORIG_BAD},
    '{24'sd0, 25'sd0, 24'h7fffff, 25'h1000000, 1'b1, STAT_DEST_BAD}
  };

  // Receiver readiness, with an optional long hold-off.
  always @(negedge clk) begin
    m_axis_tready <= !recv_hold && ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // Compare each output transaction with the oldest expected result.
  always @(posedge clk) begin
    hav_result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_dist.size() == 0) begin
        $display("%0t: unexpected result distance %0d status %0d", $realtime,
                 m_axis_tdata[25:0], m_axis_tuser);
        error_count++;
      end else begin
        want = pending_dist.pop_front();
        if (m_axis_tdata[25:0] !== want.distance) begin
          $display("%0t: distance mismatch expected %0d actual %0d", $realtime,
                   want.distance, m_axis_tdata[25:0]);
          error_count++;
        end
        if (m_axis_tuser !== want.status) begin
          $display("%0t: status mismatch expected %0d actual %0d", $realtime,
                   want.status, m_axis_tuser);
          error_count++;
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("haversine_distance_test: FAIL");
      $finish;
    end
  end

  task automatic random_phase(int count, logic [15:0] radius, int s_pct, int r_pct);
    drain_results();
    write_radius(radius);
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    repeat (count) send_pair(random_pair());
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed pairs at the reset radius.
    send_idle_pct = 33;
    recv_idle_pct = 58;
    foreach (directed_rows[i]) send_pair(directed_rows[i]);

    random_phase(250, 16'd6371, 33, 58);
    random_phase(250, 16'd1, 58, 33);
    random_phase(200, 16'd65535, 0, 0);

    // Long receiver stall while the sender keeps offering pairs. The sender
    // spreads its pairs over more cycles than the pipeline is deep, so the
    // first result reaches the output while pairs are still offered and the
    // input stalls.
    drain_results();
    write_radius(16'($urandom_range(1, 65535)));
    send_idle_pct = 80;
    fork
      begin
        recv_hold = 1'b1;
        repeat (3000) @(posedge clk);
        recv_hold = 1'b0;
      end
    join_none
    repeat (300) send_pair(random_pair());

    drain_results();
    repeat (900) @(posedge clk);
    if (error_count == 0 && pending_dist.size() == 0) begin
      $display("haversine_distance_test: PASS");
    end else begin
      $display("haversine_distance_test: FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== files.f =====
src/hvd_pkg.sv
src/hvd_fifo.sv
src/hvd_front.sv
src/hvd_sin.sv
src/hvd_back.sv
src/haversine_distance.sv
test/haversine_distance_test.sv
